### src/srs_pkg.sv
`default_nettype none

package srs_pkg;

    // Fixed-point format of every x and f value.
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;

    // Widths fixed by the ports.
    localparam int FIELD_BITS     = 32;
    localparam int TARGET_BITS    = 31;
    localparam int TOL_BITS       = 25;
    localparam int LIMIT_BITS     = 7;
    localparam int STEPS_BITS     = 6;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Scalar arithmetic width, wide enough for any sum of a word, a field and a register.
    localparam int EXT_BITS = ((WORD_BITS > FIELD_BITS) ? WORD_BITS : FIELD_BITS) + 3;

    localparam logic [TARGET_BITS-1:0] TARGET_RESET = TARGET_BITS'(33554432);
    localparam logic [TOL_BITS-1:0]    TOL_RESET    = TOL_BITS'(17);
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = LIMIT_BITS'(50);
    localparam logic [LIMIT_BITS-1:0]  LIMIT_CAP    = LIMIT_BITS'(64);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOL    = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT  = CFG_INDEX_BITS'(2);

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_CONVERGED = 2'd0,
        STATUS_LIMIT     = 2'd1,
        STATUS_ZERO_DIV  = 2'd2
    } srs_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SQ0_WAIT,
        ST_SQ1_WAIT,
        ST_CHECK,
        ST_LOOP,
        ST_MUL_WAIT,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_SQN,
        ST_SQN_WAIT,
        ST_DONE
    } srs_state_t;

endpackage

`default_nettype wire

### src/secant_root_solver_core.sv
// Secant-method root finder for f(x) = x*x - c on signed Q8.24 words. Each input item
// carries two starting guesses; one result item follows with the root, the number of
// secant steps and a status (converged, limit reached, zero divisor). Items are handled
// one at a time: the input is ready only while the solver is idle, but a finished result
// sits in an output register, so a new item may enter before it is taken. All arithmetic
// runs on one bit-serial multiplier and one bit-serial divider. Setup computes the two
// squares, and each secant step a multiply, a divide and the square of the new point;
// the step limit is capped at 64. The input is ready again as the result becomes valid,
// or only once the previous result has been taken if it still waits. Configuration
// writes are always ready and take effect at once.
`default_nettype none

module secant_root_solver_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [srs_pkg::FIELD_BITS-1:0] first_guess,
    input  logic signed [srs_pkg::FIELD_BITS-1:0] second_guess,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [srs_pkg::FIELD_BITS-1:0] root,
    output logic [srs_pkg::STEPS_BITS-1:0]        steps_taken,
    output logic [srs_pkg::STATUS_BITS-1:0]       status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [srs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [srs_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int W  = srs_pkg::WORD_BITS;
    localparam int F  = srs_pkg::FRAC_BITS;
    localparam int EW = srs_pkg::EXT_BITS;
    localparam int FB = srs_pkg::FIELD_BITS;
    localparam int TB = srs_pkg::TARGET_BITS;
    localparam int OB = srs_pkg::TOL_BITS;
    localparam int LB = srs_pkg::LIMIT_BITS;
    localparam int SB = srs_pkg::STEPS_BITS;

    localparam logic signed [EW-1:0] WMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] WMIN_E = ~WMAX_E;
    localparam logic [2*W-1:0]       SQ_MAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};

    function automatic logic signed [W-1:0] sat_word(input logic signed [EW-1:0] v);
        logic signed [W-1:0] r;
        if (v > WMAX_E)
            r = WMAX_E[W-1:0];
        else if (v < WMIN_E)
            r = WMIN_E[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    function automatic logic signed [EW-1:0] ext_word(input logic signed [W-1:0] v);
        return {{(EW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] ext_field(input logic signed [FB-1:0] v);
        return {{(EW-FB){v[FB-1]}}, v};
    endfunction

    function automatic logic [EW-1:0] mag_ext(input logic signed [EW-1:0] v);
        return v[EW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] abs_word(input logic signed [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // f(x) from the exact square of |x|: drop the fraction bits, saturate, subtract c.
    function automatic logic signed [W-1:0] f_of_square(input logic [2*W-1:0] p,
                                                        input logic [TB-1:0] c);
        logic [2*W-1:0] sh;
        logic [W-1:0]   sq;
        sh = p >> F;
        if (sh > SQ_MAX)
            sq = SQ_MAX[W-1:0];
        else
            sq = sh[W-1:0];
        return sat_word($signed({{(EW-W){1'b0}}, sq}) - $signed({{(EW-TB){1'b0}}, c}));
    endfunction

    srs_pkg::srs_state_t  state_reg, state_next;

    logic [TB-1:0] target_reg;
    logic [OB-1:0] tol_reg;
    logic [LB-1:0] limit_reg;

    logic signed [W-1:0] x0_reg, x0_next;
    logic signed [W-1:0] x1_reg, x1_next;
    logic signed [W-1:0] y0_reg, y0_next;
    logic signed [W-1:0] y1_reg, y1_next;
    logic signed [W-1:0] q_reg, q_next;
    logic [W-1:0]        dm_reg, dm_next;
    logic                neg_reg, neg_next;
    logic [LB-1:0]       n_reg, n_next;
    srs_pkg::srs_status_t run_status_reg, run_status_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic signed [FB-1:0] root_reg;
    logic [SB-1:0]        steps_reg;
    srs_pkg::srs_status_t status_reg;

    logic                 mul_start, mul_done;
    logic [W-1:0]         mul_a, mul_b;
    logic [2*W-1:0]       mul_product;
    logic                 div_start, div_done;
    logic [W-1:0]         div_quotient;

    logic [LB-1:0]        limit_eff;
    logic [EW-1:0]        tol_ext;
    logic signed [EW-1:0] dx_ext, dy_ext, q_ext, root_ext;
    logic [EW-1:0]        dx_mag, dy_mag;
    logic [LB-1:0]        n_minus;

    assign limit_eff = (limit_reg > srs_pkg::LIMIT_CAP) ? srs_pkg::LIMIT_CAP : limit_reg;
    assign tol_ext   = {{(EW-OB){1'b0}}, tol_reg};
    assign dx_ext    = ext_word(x1_reg) - ext_word(x0_reg);
    assign dy_ext    = ext_word(y1_reg) - ext_word(y0_reg);
    assign dx_mag    = mag_ext(dx_ext);
    assign dy_mag    = mag_ext(dy_ext);
    assign q_ext     = $signed({{(EW-W){1'b0}}, div_quotient});
    assign root_ext  = ext_word(x1_reg);
    assign n_minus   = n_reg - 1'b1;

    srs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    srs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (dm_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next      = state_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y0_next         = y0_reg;
        y1_next         = y1_reg;
        q_next          = q_reg;
        dm_next         = dm_reg;
        neg_next        = neg_reg;
        n_next          = n_reg;
        run_status_next = run_status_reg;
        in_ready        = 1'b0;
        mul_start       = 1'b0;
        mul_a           = abs_word(x0_reg);
        mul_b           = abs_word(x0_reg);
        div_start       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            srs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    x0_next         = sat_word(ext_field(first_guess));
                    x1_next         = sat_word(ext_field(second_guess));
                    n_next          = LB'(1);
                    run_status_next = srs_pkg::STATUS_CONVERGED;
                    state_next      = srs_pkg::ST_PUSH;
                end
            end
            srs_pkg::ST_PUSH:
            begin
                // Guesses too close together: move the second one up by four tolerances.
                if (dx_mag < tol_ext)
                    x1_next = sat_word(ext_word(x1_reg) + $signed(tol_ext << 2));
                mul_start  = 1'b1;
                state_next = srs_pkg::ST_SQ0_WAIT;
            end
            srs_pkg::ST_SQ0_WAIT:
            begin
                mul_a = abs_word(x1_reg);
                mul_b = abs_word(x1_reg);
                if (mul_done)
                begin
                    y0_next    = f_of_square(mul_product, target_reg);
                    mul_start  = 1'b1;
                    state_next = srs_pkg::ST_SQ1_WAIT;
                end
            end
            srs_pkg::ST_SQ1_WAIT:
            begin
                if (mul_done)
                begin
                    y1_next    = f_of_square(mul_product, target_reg);
                    state_next = srs_pkg::ST_CHECK;
                end
            end
            srs_pkg::ST_CHECK:
            begin
                if (y0_reg == '0)
                begin
                    x1_next    = x0_reg;
                    state_next = srs_pkg::ST_DONE;
                end
                else if (y1_reg == '0)
                    state_next = srs_pkg::ST_DONE;
                else
                    state_next = srs_pkg::ST_LOOP;
            end
            srs_pkg::ST_LOOP:
            begin
                mul_a = abs_word(y1_reg);
                mul_b = dx_mag[W-1:0];
                if ((n_reg < limit_eff) && (dx_mag > tol_ext))
                begin
                    if (y1_reg == y0_reg)
                    begin
                        run_status_next = srs_pkg::STATUS_ZERO_DIV;
                        state_next      = srs_pkg::ST_DONE;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        dm_next    = dy_mag[W-1:0];
                        neg_next   = y1_reg[W-1] ^ dx_ext[EW-1] ^ dy_ext[EW-1];
                        state_next = srs_pkg::ST_MUL_WAIT;
                    end
                end
                else
                begin
                    run_status_next = (dx_mag > tol_ext) ? srs_pkg::STATUS_LIMIT
                                                         : srs_pkg::STATUS_CONVERGED;
                    state_next      = srs_pkg::ST_DONE;
                end
            end
            srs_pkg::ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = srs_pkg::ST_DIV_WAIT;
                end
            end
            srs_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    q_next     = sat_word(neg_reg ? -q_ext : q_ext);
                    state_next = srs_pkg::ST_UPDATE;
                end
            end
            srs_pkg::ST_UPDATE:
            begin
                x0_next    = x1_reg;
                x1_next    = sat_word(ext_word(x1_reg) - ext_word(q_reg));
                y0_next    = y1_reg;
                n_next     = n_reg + 1'b1;
                state_next = srs_pkg::ST_SQN;
            end
            srs_pkg::ST_SQN:
            begin
                mul_a      = abs_word(x1_reg);
                mul_b      = abs_word(x1_reg);
                mul_start  = 1'b1;
                state_next = srs_pkg::ST_SQN_WAIT;
            end
            srs_pkg::ST_SQN_WAIT:
            begin
                if (mul_done)
                begin
                    y1_next    = f_of_square(mul_product, target_reg);
                    state_next = srs_pkg::ST_LOOP;
                end
            end
            srs_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = srs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= srs_pkg::TARGET_RESET;
            tol_reg    <= srs_pkg::TOL_RESET;
            limit_reg  <= srs_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                srs_pkg::CFG_TARGET: target_reg <= cfg_data[TB-1:0];
                srs_pkg::CFG_TOL:    tol_reg    <= cfg_data[OB-1:0];
                srs_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[LB-1:0];
                default:
                begin
                    target_reg <= target_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg         <= x0_next;
        x1_reg         <= x1_next;
        y0_reg         <= y0_next;
        y1_reg         <= y1_next;
        q_reg          <= q_next;
        dm_reg         <= dm_next;
        neg_reg        <= neg_next;
        n_reg          <= n_next;
        run_status_reg <= run_status_next;
        if (out_load)
        begin
            root_reg   <= root_ext[FB-1:0];
            steps_reg  <= n_minus[SB-1:0];
            status_reg <= run_status_reg;
        end
    end

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign root        = root_reg;
    assign steps_taken = steps_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

### src/srs_mul.sv
`default_nettype none

// Shift-and-add multiplier of two unsigned words, one multiplier bit per cycle.
module srs_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [srs_pkg::WORD_BITS-1:0]     a,
    input  logic [srs_pkg::WORD_BITS-1:0]     b,
    output logic                              done,
    output logic [2*srs_pkg::WORD_BITS-1:0]   product
);

    localparam int W   = srs_pkg::WORD_BITS;
    localparam int MCW = $clog2(W);
    localparam logic [MCW-1:0] MUL_LAST = MCW'(W - 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [MCW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]   a_reg, a_next;
    logic [W-1:0]   hi_reg, hi_next;
    logic [W-1:0]   lo_reg, lo_next;
    logic [W:0]     sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(W+1){1'b0}});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
        end
        else if (busy_reg)
        begin
            // The low half holds the unused multiplier bits and collects product bits.
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

### src/srs_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, quotient capped at half the word range.
module srs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [2*srs_pkg::WORD_BITS-1:0]   dividend,
    input  logic [srs_pkg::WORD_BITS-1:0]     divisor,
    output logic                              done,
    output logic [srs_pkg::WORD_BITS-1:0]     quotient
);

    localparam int W   = srs_pkg::WORD_BITS;
    localparam int DCW = $clog2(2 * W);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(2 * W - 1);
    localparam logic [W:0]     QCAP     = {2'b01, {(W-1){1'b0}}};

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DCW-1:0] cnt_reg, cnt_next;
    logic [2*W-1:0] dvd_reg, dvd_next;
    logic [W-1:0]   dm_reg, dm_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   q_reg, q_next;
    logic [W:0]     shifted;
    logic [W:0]     diff;
    logic           ge;
    logic [W:0]     qcand;

    assign shifted = {rem_reg, dvd_reg[2*W-1]};
    assign diff    = shifted - {1'b0, dm_reg};
    assign ge      = (shifted >= {1'b0, dm_reg});
    assign qcand   = {q_reg, ge};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dm_next   = dm_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dm_next   = divisor;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[2*W-2:0], 1'b0};
            rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
            // Once the quotient passes the cap it stays there, which is all the caller needs.
            q_next   = (qcand > QCAP) ? QCAP[W-1:0] : qcand[W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dm_reg  <= dm_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire
